// ===== rtl/core/fpr_pkg.sv =====
// Shared types and constants for the FIFO page replacement core.
// Used by the controller, datapath and top level; depends on nothing.
package fpr_pkg;

    localparam int VA_WIDTH     = 16;
    localparam int PAGE_BYTES   = 256;
    localparam int OFFSET_W     = $clog2(PAGE_BYTES);
    localparam int NUM_PAGES    = 256;
    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int FRAME_OUT_W  = 4;
    localparam int COUNT_W      = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } fpr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } fpr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } fpr_status_t;

endpackage

// ===== rtl/core/fifo_page_replacement_core.sv =====
// FIFO page replacement core: one virtual address in, one hit/fault result out.
// The page table is read at input acceptance; the table update and the result register
// are written on leaving the lookup state, which waits while the result is stalled.
// One address is in flight at a time: the registered table read precedes its write-back;
// a stalled result holds the next lookup until taken.
// Reset (aresetn, synchronous, active low) invalidates every page at once and clears
// the fill count, victim pointer and fault counter. Uses fpr_pkg, fpr_ctrl, fpr_datapath.
module fifo_page_replacement_core #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fpr_pkg::VA_WIDTH-1:0]      s_virtual_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_page_fault,
    output logic [fpr_pkg::FRAME_OUT_W-1:0]   m_frame_number,
    output logic                              m_evicted,
    output logic [fpr_pkg::PAGE_W-1:0]        m_evicted_page,
    output logic [fpr_pkg::COUNT_W-1:0]       m_fault_total
);

    fpr_pkg::fpr_cmd_t    cmd;
    fpr_pkg::fpr_status_t status;

    fpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fpr_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_page_fault      (m_page_fault),
        .m_frame_number    (m_frame_number),
        .m_evicted         (m_evicted),
        .m_evicted_page    (m_evicted_page),
        .m_fault_total     (m_fault_total)
    );

endmodule

// ===== rtl/core/fpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fpr_ctrl.sv =====
// Controller state machine for the FIFO page replacement core.
// Depends on fpr_pkg for the state, command and status types.
module fpr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fpr_pkg::fpr_status_t status,
    output fpr_pkg::fpr_cmd_t    cmd
);

    fpr_pkg::fpr_state_t state_reg;
    fpr_pkg::fpr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fpr_pkg::ST_LOOKUP;
                end
            end
            fpr_pkg::ST_LOOKUP: begin
                if (!status.out_stall) begin
                    state_next = fpr_pkg::ST_IDLE;
                end
            end
            default: state_next = fpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            fpr_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            fpr_pkg::ST_LOOKUP: begin
                // The result register must be free or emptying this cycle.
                cmd.commit = !status.out_stall;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Only one transaction is in flight at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a lookup is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (state_reg == fpr_pkg::ST_LOOKUP))
        else $error("commit issued outside the lookup state");

endmodule

// ===== rtl/core/fpr_datapath.sv =====
// Datapath of the FIFO page replacement core: page table, frame owners,
// fill count, victim pointer, fault counter and result register. Uses fpr_pkg and fpr_ram.
module fpr_datapath #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fpr_pkg::fpr_cmd_t                 cmd,
    output fpr_pkg::fpr_status_t              status,
    input  logic [fpr_pkg::VA_WIDTH-1:0]      s_virtual_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_page_fault,
    output logic [fpr_pkg::FRAME_OUT_W-1:0]   m_frame_number,
    output logic                              m_evicted,
    output logic [fpr_pkg::PAGE_W-1:0]        m_evicted_page,
    output logic [fpr_pkg::COUNT_W-1:0]       m_fault_total
);

    localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FCW = $clog2(NUM_FRAMES + 1);

    logic [fpr_pkg::NUM_PAGES-1:0]   valid_reg;
    logic [fpr_pkg::NUM_PAGES-1:0]   valid_next;
    logic [FCW-1:0]                  filled_reg;
    logic [FCW-1:0]                  filled_next;
    logic [FW-1:0]                   victim_reg;
    logic [FW-1:0]                   victim_next;
    logic [fpr_pkg::COUNT_W-1:0]     count_reg;
    logic [fpr_pkg::COUNT_W-1:0]     count_next;
    logic [fpr_pkg::PAGE_W-1:0]      page_reg;
    logic                            m_valid_reg;

    logic [fpr_pkg::PAGE_W-1:0]      page_in;
    logic [FW-1:0]                   map_rdata;
    logic [fpr_pkg::PAGE_W-1:0]      owner_rdata;
    logic                            hit;
    logic                            full;
    logic [FW-1:0]                   frame_sel;
    logic                            evict;
    logic [FW+fpr_pkg::FRAME_OUT_W-1:0] frame_ext;

    assign page_in = s_virtual_address[fpr_pkg::VA_WIDTH-1 -: fpr_pkg::PAGE_W];

    // Frame number of each page; meaningful only where the valid bit is set.
    fpr_ram #(
        .WIDTH (FW),
        .DEPTH (fpr_pkg::NUM_PAGES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (cmd.commit && !hit),
        .waddr (page_reg),
        .wdata (frame_sel),
        .re    (cmd.capture),
        .raddr (page_in),
        .rdata (map_rdata)
    );

    // Page held by each frame. Read at the victim pointer, which only moves
    // once every frame has been written.
    fpr_ram #(
        .WIDTH (fpr_pkg::PAGE_W),
        .DEPTH (NUM_FRAMES)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (cmd.commit && !hit),
        .waddr (frame_sel),
        .wdata (page_reg),
        .re    (cmd.capture),
        .raddr (victim_reg),
        .rdata (owner_rdata)
    );

    always_comb begin
        hit         = valid_reg[page_reg];
        full        = (filled_reg == FCW'(NUM_FRAMES));
        evict       = !hit && full;
        valid_next  = valid_reg;
        filled_next = filled_reg;
        victim_next = victim_reg;
        count_next  = count_reg;
        if (hit) begin
            frame_sel = map_rdata;
        end else if (!full) begin
            frame_sel = filled_reg[FW-1:0];
        end else begin
            frame_sel = victim_reg;
        end
        if (!hit) begin
            if (count_reg != '1) begin
                count_next = count_reg + 1'b1;
            end
            if (!full) begin
                filled_next = filled_reg + 1'b1;
            end else begin
                valid_next[owner_rdata] = 1'b0;
                victim_next = (victim_reg == FW'(NUM_FRAMES - 1)) ? '0 : victim_reg + 1'b1;
            end
            valid_next[page_reg] = 1'b1;
        end
        frame_ext = {{fpr_pkg::FRAME_OUT_W{1'b0}}, frame_sel};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            filled_reg  <= '0;
            victim_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                valid_reg   <= valid_next;
                filled_reg  <= filled_next;
                victim_reg  <= victim_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            page_reg <= page_in;
        end
        if (cmd.commit) begin
            m_page_fault   <= !hit;
            m_frame_number <= frame_ext[fpr_pkg::FRAME_OUT_W-1:0];
            m_evicted      <= evict;
            m_evicted_page <= evict ? owner_rdata : '0;
            m_fault_total  <= count_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign status.out_stall = m_valid_reg && !m_ready;

    assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= FCW'(NUM_FRAMES))
        else $error("fill count beyond the number of frames");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (victim_reg != '0) |-> full)
        else $error("victim pointer moved before all frames were filled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_page_fault) |-> (m_fault_total != '0))
        else $error("fault reported with a zero fault total");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> m_page_fault)
        else $error("eviction reported on a hit");

endmodule
